// ----- hdl/lpl_pkg.sv -----
package lpl_pkg;

  localparam int MAX_WINDOW = 64;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int CEIL_W   = 15;
  localparam int REL_W    = 16;
  localparam int WIN_W    = 7;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;
  localparam int FRAC_W   = 15;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(32768);

  // effective window length, 1..MAX_WINDOW
  localparam int WEFF_W = $clog2(MAX_WINDOW + 1);

  // scan must outlast both the min/tap chains and the divider
  localparam int SCAN_CYCLES = (MAX_WINDOW > FRAC_W + 1) ? MAX_WINDOW : FRAC_W + 1;
  localparam int SCAN_W      = $clog2(SCAN_CYCLES);

  localparam int DIV_STEPS = FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [IDX_W-1:0] REG_CEILING = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_RELEASE = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_WINDOW  = IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;   // ring clear on window write
    logic shift;   // commit: every cell takes its neighbor's entry
    logic active;  // cell lies inside the window
    logic tap;     // cell holds the oldest entry
  } cell_ctl_t;

  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] quot;
  } div_res_t;

endpackage

// ----- hdl/lpl_cell.sv -----
module lpl_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lpl_pkg::cell_ctl_t                  ctl,
  input  logic signed [lpl_pkg::SAMPLE_W-1:0] sample_prev,
  input  logic        [lpl_pkg::GAIN_W-1:0]   gain_prev,
  input  logic        [lpl_pkg::GAIN_W-1:0]   min_prev,
  input  logic signed [lpl_pkg::SAMPLE_W-1:0] pick_prev,
  output logic signed [lpl_pkg::SAMPLE_W-1:0] sample_o,
  output logic        [lpl_pkg::GAIN_W-1:0]   gain_o,
  output logic        [lpl_pkg::GAIN_W-1:0]   min_o,
  output logic signed [lpl_pkg::SAMPLE_W-1:0] pick_o
);

  logic signed [lpl_pkg::SAMPLE_W-1:0] sample_r;
  logic        [lpl_pkg::GAIN_W-1:0]   gain_r;
  logic        [lpl_pkg::GAIN_W-1:0]   min_r;
  logic signed [lpl_pkg::SAMPLE_W-1:0] pick_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sample_r <= '0;
      gain_r   <= lpl_pkg::UNITY;
    end else if (ctl.shift) begin
      sample_r <= sample_prev;
      gain_r   <= gain_prev;
    end
  end

  // free-running chains: running min and oldest-sample pick move one cell per cycle
  always_ff @(posedge clk) begin
    min_r  <= (ctl.active && (gain_r < min_prev)) ? gain_r : min_prev;
    pick_r <= ctl.tap ? sample_r : pick_prev;
  end

  assign sample_o = sample_r;
  assign gain_o   = gain_r;
  assign min_o    = min_r;
  assign pick_o   = pick_r;

endmodule

// ----- hdl/lpl_div.sv -----
module lpl_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [lpl_pkg::CEIL_W-1:0]          ceil_val,
  input  logic [lpl_pkg::SAMPLE_W-1:0]        mag,
  output lpl_pkg::div_res_t                   res
);

  logic [lpl_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [lpl_pkg::SAMPLE_W-1:0]  rem_r;
  logic [lpl_pkg::SAMPLE_W-1:0]  den_r;
  logic [lpl_pkg::FRAC_W-1:0]    quo_r;
  logic                          bypass_r;
  logic [lpl_pkg::SAMPLE_W:0]    rem2;
  logic                          fits;

  assign rem2 = {rem_r, 1'b0};
  assign fits = (rem2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= lpl_pkg::DIV_CNT_W'(lpl_pkg::DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // restoring division of ceiling*2^15 by |x|, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r    <= {1'b0, ceil_val};
      den_r    <= mag;
      quo_r    <= '0;
      bypass_r <= (mag <= {1'b0, ceil_val});
    end else if (cnt_r != '0) begin
      if (fits) begin
        rem_r <= lpl_pkg::SAMPLE_W'(rem2 - {1'b0, den_r});
      end else begin
        rem_r <= rem2[lpl_pkg::SAMPLE_W-1:0];
      end
      quo_r <= {quo_r[lpl_pkg::FRAC_W-2:0], fits};
    end
  end

  assign res.busy = (cnt_r != '0);
  assign res.quot = bypass_r ? lpl_pkg::UNITY : {1'b0, quo_r};

endmodule

// ----- hdl/lookahead_peak_limiter.sv -----
// Each input is scanned, committed, multiplied and then loaded into the output
// register; the 64-cell min/tap chain sets the scan length. No new input is
// taken before the result is loaded, which waits on a full output register.
// A result waiting in the output register does not block the next input.
// Reset (rst_n low, synchronous): control registers to defaults, ring cleared
// to samples 0, unity gains, running gain unity. A window write clears likewise.
module lookahead_peak_limiter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lpl_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lpl_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_we,
  input  logic [lpl_pkg::IDX_W-1:0]           cfg_index,
  input  logic [lpl_pkg::CFG_W-1:0]           cfg_data
);

  localparam int PROD_W = lpl_pkg::SAMPLE_W + lpl_pkg::GAIN_W + 1;
  localparam int SH_W   = PROD_W - lpl_pkg::FRAC_W;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(2 ** (lpl_pkg::SAMPLE_W - 1) - 1);
  localparam logic signed [SH_W-1:0] SAT_MIN = SH_W'(-(2 ** (lpl_pkg::SAMPLE_W - 1)));

  lpl_pkg::state_t state_r, state_nxt;
  logic [lpl_pkg::SCAN_W-1:0] cnt_r, cnt_nxt;

  logic [lpl_pkg::CEIL_W-1:0] ceiling_r;
  logic [lpl_pkg::REL_W-1:0]  release_r;
  logic [lpl_pkg::WIN_W-1:0]  window_r;

  logic signed [lpl_pkg::SAMPLE_W-1:0] x_r;
  logic signed [lpl_pkg::SAMPLE_W-1:0] old_r;
  logic        [lpl_pkg::GAIN_W-1:0]   cur_gain_r, cur_gain_nxt;
  logic signed [PROD_W-1:0]            prod_r;
  logic                                out_valid_r;
  logic signed [lpl_pkg::SAMPLE_W-1:0] out_sample_r, sat_nxt;

  logic accept, do_shift, load_out, win_wr;
  logic [lpl_pkg::CEIL_W-1:0]   ceil_eff;
  logic [lpl_pkg::REL_W-1:0]    rel_eff;
  logic [lpl_pkg::WEFF_W-1:0]   win_eff;
  logic [lpl_pkg::SAMPLE_W-1:0] mag;
  logic [lpl_pkg::GAIN_W-1:0]   win_min;
  logic [lpl_pkg::GAIN_W:0]     gain_sum;
  logic signed [SH_W-1:0]       shifted;
  lpl_pkg::div_res_t            div_res;

  lpl_pkg::cell_ctl_t                  ctl_w    [lpl_pkg::MAX_WINDOW];
  logic signed [lpl_pkg::SAMPLE_W-1:0] sample_w [lpl_pkg::MAX_WINDOW];
  logic        [lpl_pkg::GAIN_W-1:0]   gain_w   [lpl_pkg::MAX_WINDOW];
  logic        [lpl_pkg::GAIN_W-1:0]   min_w    [lpl_pkg::MAX_WINDOW];
  logic signed [lpl_pkg::SAMPLE_W-1:0] pick_w   [lpl_pkg::MAX_WINDOW];

  assign accept = in_valid && in_ready;
  assign win_wr = cfg_we && (cfg_index == lpl_pkg::REG_WINDOW);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= lpl_pkg::CEIL_W'(32767);
      release_r <= lpl_pkg::REL_W'(16);
      window_r  <= lpl_pkg::WIN_W'(64);
    end else if (cfg_we) begin
      if (cfg_index == lpl_pkg::REG_CEILING) begin
        ceiling_r <= cfg_data[lpl_pkg::CEIL_W-1:0];
      end
      if (cfg_index == lpl_pkg::REG_RELEASE) begin
        release_r <= cfg_data[lpl_pkg::REL_W-1:0];
      end
      if (cfg_index == lpl_pkg::REG_WINDOW) begin
        window_r <= cfg_data[lpl_pkg::WIN_W-1:0];
      end
    end
  end

  always_comb begin
    ceil_eff = (ceiling_r == '0) ? lpl_pkg::CEIL_W'(1) : ceiling_r;
    rel_eff  = (release_r == '0) ? lpl_pkg::REL_W'(1) : release_r;
    if (window_r == '0) begin
      win_eff = lpl_pkg::WEFF_W'(1);
    end else if (32'(window_r) > lpl_pkg::MAX_WINDOW) begin
      win_eff = lpl_pkg::WEFF_W'(lpl_pkg::MAX_WINDOW);
    end else begin
      win_eff = lpl_pkg::WEFF_W'(window_r);
    end
  end

  // |x|; the most negative sample maps to 32768
  assign mag = in_sample_in[lpl_pkg::SAMPLE_W-1] ?
               lpl_pkg::SAMPLE_W'(~in_sample_in + 1'b1) : lpl_pkg::SAMPLE_W'(in_sample_in);

  lpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .ceil_val (ceil_eff),
    .mag      (mag),
    .res      (div_res)
  );

  // cell chain: cell 0 is the newest entry
  always_comb begin
    for (int i = 0; i < lpl_pkg::MAX_WINDOW; i++) begin
      ctl_w[i].clear  = win_wr;
      ctl_w[i].shift  = do_shift;
      ctl_w[i].active = (lpl_pkg::WEFF_W'(i) < win_eff);
      ctl_w[i].tap    = (lpl_pkg::WEFF_W'(i + 1) == win_eff);
    end
  end

  for (genvar i = 0; i < lpl_pkg::MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      lpl_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl_w[i]),
        .sample_prev (x_r),
        .gain_prev   (div_res.quot),
        .min_prev    (lpl_pkg::UNITY),
        .pick_prev   ('0),
        .sample_o    (sample_w[i]),
        .gain_o      (gain_w[i]),
        .min_o       (min_w[i]),
        .pick_o      (pick_w[i])
      );
    end else begin : g_body
      lpl_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl_w[i]),
        .sample_prev (sample_w[i-1]),
        .gain_prev   (gain_w[i-1]),
        .min_prev    (min_w[i-1]),
        .pick_prev   (pick_w[i-1]),
        .sample_o    (sample_w[i]),
        .gain_o      (gain_w[i]),
        .min_o       (min_w[i]),
        .pick_o      (pick_w[i])
      );
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpl_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    do_shift  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      lpl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = lpl_pkg::ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      lpl_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lpl_pkg::SCAN_W'(lpl_pkg::SCAN_CYCLES - 1)) begin
          state_nxt = lpl_pkg::ST_COMMIT;
        end
      end
      lpl_pkg::ST_COMMIT: begin
        do_shift  = 1'b1;
        state_nxt = lpl_pkg::ST_MUL;
      end
      lpl_pkg::ST_MUL: begin
        state_nxt = lpl_pkg::ST_OUT;
      end
      lpl_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = lpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpl_pkg::ST_IDLE;
      end
    endcase
  end

  // gain: previous plus release, capped by window min and the new gain
  always_comb begin
    win_min      = (div_res.quot < min_w[lpl_pkg::MAX_WINDOW-1]) ?
                   div_res.quot : min_w[lpl_pkg::MAX_WINDOW-1];
    gain_sum     = {1'b0, cur_gain_r} + {1'b0, rel_eff};
    cur_gain_nxt = (gain_sum > {1'b0, win_min}) ? win_min : gain_sum[lpl_pkg::GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || win_wr) begin
      cur_gain_r <= lpl_pkg::UNITY;
    end else if (do_shift) begin
      cur_gain_r <= cur_gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_sample_in;
    end
    if (do_shift) begin
      old_r <= pick_w[lpl_pkg::MAX_WINDOW-1];
    end
    if (state_r == lpl_pkg::ST_MUL) begin
      prod_r <= $signed(old_r) * $signed({1'b0, cur_gain_r});
    end
  end

  assign shifted = prod_r[PROD_W-1:lpl_pkg::FRAC_W];

  always_comb begin
    if (shifted > SAT_MAX) begin
      sat_nxt = SAT_MAX[lpl_pkg::SAMPLE_W-1:0];
    end else if (shifted < SAT_MIN) begin
      sat_nxt = SAT_MIN[lpl_pkg::SAMPLE_W-1:0];
    end else begin
      sat_nxt = shifted[lpl_pkg::SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= sat_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == lpl_pkg::ST_SCAN) && (cnt_r == '0))
    else $error("transaction accepted without starting a scan");

  a_div_done_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpl_pkg::ST_COMMIT) |-> !div_res.busy && (div_res.quot <= lpl_pkg::UNITY))
    else $error("divider still running or out of range at commit");

  a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cur_gain_r <= lpl_pkg::UNITY)
    else $error("running gain above unity");

  a_window_write_resets_gain: assert property (@(posedge clk) disable iff (!rst_n)
    win_wr |=> (cur_gain_r == lpl_pkg::UNITY))
    else $error("window write did not reset the running gain");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending transaction");

endmodule
